/* src/smbus_wm_pkg.sv */
// Package: phase codes, CRC-8 helper and register indexes for the SMBus word master.
package smbus_wm_pkg;

  localparam int unsigned HpW = 16;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START_A = 5'd1,
    PH_START_B = 5'd2,
    PH_START_C = 5'd3,
    PH_START_D = 5'd4,
    PH_TX_LO   = 5'd5,
    PH_TX_HI   = 5'd6,
    PH_ACK_LO  = 5'd7,
    PH_ACK_HI  = 5'd8,
    PH_RX_LO   = 5'd9,
    PH_RX_HI   = 5'd10,
    PH_MACK_LO = 5'd11,
    PH_MACK_HI = 5'd12,
    PH_STOP_A  = 5'd13,
    PH_STOP_B  = 5'd14,
    PH_STOP_C  = 5'd15
  } phase_t;

  localparam logic [1:0] REG_ADDR  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_HALF  = 2'd2;

  localparam logic [7:0] CrcPoly = 8'h07;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/smbus_word_master_with_pec.sv */
// Top level: SMBus read-word / write-word master with PEC, one bus tick per item.
//
// Usage: every accepted input item is one tick of the bus timebase. Its
// tdata carries go, opcode, command_code, write_word and the sampled SDA
// level. Each accepted item yields exactly one result item carrying the
// SCL level, the SDA pull-low enable, busy, done, success, the received
// word and the attempt count for that tick.
// The result of an item is registered when the item is accepted.
// Throughput: one item per cycle while the receiver takes results; the phase
// state machine and tick divider update in one pass of logic per item.
// A go while idle latches the request; the transaction starts on the next
// item. Each bus segment lasts half_period_ticks items, or one item if zero.
// Reset clears the state machine to idle, counters and received bytes to
// zero and the registers to their defaults (address 90, five attempts,
// 250 ticks per half period).
// When the receiver stalls, the result register holds and s_tready drops
// only while a result waits and no new one can be stored.
// Registers are written over the APB port at byte addresses 0, 4 and 8.
module smbus_word_master_with_pec
  import smbus_wm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] go, [1] opcode, [9:2] command_code, [25:10] write_word, [26] sda_sample
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res, [4] success,
  // [20:5] read_word, [24:21] attempts_used
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [6:0]     device_address;
  logic [3:0]     attempt_limit;
  logic [HpW-1:0] half_period_ticks;

  // state
  phase_t         phase;
  logic [HpW-1:0] tick_divider;
  logic [3:0]     bit_count;
  logic [2:0]     byte_index;
  logic [7:0]     shift_byte;
  logic [7:0]     rx0, rx1, rx2;
  logic [7:0]     crc_value;
  logic [3:0]     attempt_count;
  logic           req_write;
  logic [7:0]     req_cmd;
  logic [15:0]    req_word;

  phase_t         phase_next;
  logic [HpW-1:0] tick_divider_next;
  logic [3:0]     bit_count_next;
  logic [2:0]     byte_index_next;
  logic [7:0]     shift_byte_next;
  logic [7:0]     rx0_next, rx1_next, rx2_next;
  logic [7:0]     crc_value_next;
  logic [3:0]     attempt_count_next;
  logic           req_write_next;
  logic [7:0]     req_cmd_next;
  logic [15:0]    req_word_next;
  logic [31:0]    result;

  logic accept;
  logic wr_en;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_ADDR:  prdata = {25'd0, device_address};
      REG_LIMIT: prdata = {28'd0, attempt_limit};
      REG_HALF:  prdata = {{(32-HpW){1'b0}}, half_period_ticks};
      default:   prdata = 32'd0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= 7'd90;
      attempt_limit     <= 4'd5;
      half_period_ticks <= HpW'(250);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ADDR:  device_address    <= pwdata[6:0];
        REG_LIMIT: attempt_limit     <= pwdata[3:0];
        REG_HALF:  half_period_ticks <= pwdata[HpW-1:0];
        default: ;
      endcase
    end
  end

  // one tick of the transaction engine
  always_comb begin
    logic           go, op, sda;
    logic [7:0]     cmd_in;
    logic [15:0]    word_in;
    logic           scl, pull, busy, done, ok;
    logic [HpW-1:0] hp;
    logic [3:0]     lim;
    logic [7:0]     addr_w, tx_b;
    logic [2:0]     bi;
    logic           load, begin_att;
    logic [7:0]     sh;

    go      = s_tdata[0];
    op      = s_tdata[1];
    cmd_in  = s_tdata[9:2];
    word_in = s_tdata[25:10];
    sda     = s_tdata[26];

    phase_next         = phase;
    tick_divider_next  = tick_divider;
    bit_count_next     = bit_count;
    byte_index_next    = byte_index;
    shift_byte_next    = shift_byte;
    rx0_next           = rx0;
    rx1_next           = rx1;
    rx2_next           = rx2;
    crc_value_next     = crc_value;
    attempt_count_next = attempt_count;
    req_write_next     = req_write;
    req_cmd_next       = req_cmd;
    req_word_next      = req_word;

    scl = 1'b1; pull = 1'b0; busy = 1'b1; done = 1'b0; ok = 1'b0;
    hp  = (half_period_ticks == '0) ? HpW'(1) : half_period_ticks;
    lim = (attempt_limit == 4'd0) ? 4'd1 : attempt_limit;
    addr_w = {device_address, 1'b0};
    tx_b = 8'd0;
    load = 1'b0; begin_att = 1'b0;
    bi = byte_index;
    sh = {shift_byte[6:0], sda};

    // line levels of the segment in force
    unique case (phase)
      PH_START_A: scl = 1'b0;
      PH_START_B: ;
      PH_START_C: pull = 1'b1;
      PH_START_D: begin scl = 1'b0; pull = 1'b1; end
      PH_TX_LO:   begin scl = 1'b0; pull = !shift_byte[7]; end
      PH_TX_HI:   pull = !shift_byte[7];
      PH_ACK_LO, PH_RX_LO: scl = 1'b0;
      PH_ACK_HI, PH_RX_HI: ;
      PH_MACK_LO: begin scl = 1'b0; pull = (byte_index < 3'd5); end
      PH_MACK_HI: pull = (byte_index < 3'd5);
      PH_STOP_A:  begin scl = 1'b0; pull = 1'b1; end
      PH_STOP_B:  pull = 1'b1;
      PH_STOP_C:  ;
      default:    busy = 1'b0;
    endcase

    if (phase == PH_IDLE) begin
      tick_divider_next = '0;
      if (go) begin
        req_write_next = op;
        req_cmd_next   = cmd_in;
        req_word_next  = word_in;
        attempt_count_next = 4'd0;
        begin_att = 1'b1;
      end
    end else if ({1'b0, tick_divider} + 17'd1 < {1'b0, hp}) begin
      tick_divider_next = tick_divider + HpW'(1);
    end else begin
      tick_divider_next = '0;
      unique case (phase)
        PH_START_D: load = 1'b1;
        PH_TX_HI: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_count + 4'd1;
          phase_next = (bit_count + 4'd1 >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
        end
        PH_ACK_HI: begin
          if (sda) begin
            phase_next = PH_STOP_A;
          end else begin
            bi = byte_index + 3'd1;
            byte_index_next = bi;
            if (req_write) begin
              if (bi >= 3'd5) phase_next = PH_STOP_A;
              else load = 1'b1;
            end else if (bi == 3'd2) begin
              phase_next = PH_START_A;
            end else if (bi >= 3'd3) begin
              bit_count_next = 4'd0; shift_byte_next = 8'd0; phase_next = PH_RX_LO;
            end else begin
              load = 1'b1;
            end
          end
        end
        PH_RX_HI: begin
          shift_byte_next = sh;
          bit_count_next  = bit_count + 4'd1;
          if (bit_count + 4'd1 >= 4'd8) begin
            case (byte_index)
              3'd3: rx0_next = sh;
              3'd4: rx1_next = sh;
              3'd5: rx2_next = sh;
              default: ;
            endcase
            if (byte_index < 3'd5) crc_value_next = crc8_byte(crc_value, sh);
            phase_next = PH_MACK_LO;
          end else begin
            phase_next = PH_RX_LO;
          end
        end
        PH_MACK_HI: begin
          byte_index_next = byte_index + 3'd1;
          if (byte_index + 3'd1 >= 3'd6) phase_next = PH_STOP_A;
          else begin
            bit_count_next = 4'd0; shift_byte_next = 8'd0; phase_next = PH_RX_LO;
          end
        end
        PH_STOP_C: begin
          if (req_write) ok = (byte_index == 3'd5);
          else ok = (byte_index == 3'd6) && (crc_value == rx2);
          if (ok || attempt_count >= lim) begin
            done = 1'b1; phase_next = PH_IDLE;
          end else begin
            ok = 1'b0; begin_att = 1'b1;
          end
        end
        default: phase_next = phase_t'(phase + 5'd1);
      endcase
    end

    // load the next byte to send; PEC byte goes out unhashed
    if (load) begin
      case (bi)
        3'd0: tx_b = addr_w;
        3'd1: tx_b = req_cmd;
        3'd2: tx_b = req_write ? req_word[7:0] : (addr_w | 8'd1);
        3'd3: tx_b = req_word[15:8];
        default: tx_b = crc_value;
      endcase
      if (bi < 3'd4) crc_value_next = crc8_byte(crc_value, tx_b);
      shift_byte_next = tx_b;
      bit_count_next  = 4'd0;
      phase_next      = PH_TX_LO;
    end

    // new attempt
    if (begin_att) begin
      if (attempt_count_next < 4'd15) attempt_count_next = attempt_count_next + 4'd1;
      crc_value_next  = 8'd0;
      byte_index_next = 3'd0;
      bit_count_next  = 4'd0;
      phase_next      = PH_START_A;
    end

    result = {7'd0, attempt_count_next, rx1_next, rx0_next, done & ok, done, busy, pull, scl};
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_divider  <= '0;
      bit_count     <= 4'd0;
      byte_index    <= 3'd0;
      shift_byte    <= 8'd0;
      rx0           <= 8'd0;
      rx1           <= 8'd0;
      rx2           <= 8'd0;
      crc_value     <= 8'd0;
      attempt_count <= 4'd0;
      req_write     <= 1'b0;
      req_cmd       <= 8'd0;
      req_word      <= 16'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        tick_divider  <= tick_divider_next;
        bit_count     <= bit_count_next;
        byte_index    <= byte_index_next;
        shift_byte    <= shift_byte_next;
        rx0           <= rx0_next;
        rx1           <= rx1_next;
        rx2           <= rx2_next;
        crc_value     <= crc_value_next;
        attempt_count <= attempt_count_next;
        req_write     <= req_write_next;
        req_cmd       <= req_cmd_next;
        req_word      <= req_word_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) m_tdata <= result;
  end

endmodule

/* src/smbus_wm_checker.sv */
// Checker: port-level properties of the SMBus word master, bound to the top level.
module smbus_wm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        pready
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // success only with done
  a_succ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("success without done");

  // done only while busy
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2])
    else $error("done while idle");

  // idle result releases both lines
  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[0] && !m_tdata[1])
    else $error("lines driven while idle");

  // input is open whenever output is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready && pready)
    else $error("stalled with empty output");

endmodule

bind smbus_word_master_with_pec smbus_wm_checker u_smbus_wm_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
